### sv/rpsem_pkg.sv
// Package for the radio power-state energy meter: request/result types,
// command and state codes, register map and shared constants. No dependencies.
`default_nettype none

package rpsem_pkg;

    // Default widths of the internal time and energy accumulators
    localparam int TIME_BITS_DEF   = 48;
    localparam int ENERGY_BITS_DEF = 64;

    // Fixed field widths
    localparam int CUR_W      = 20;
    localparam int VOLT_W     = 13;
    localparam int STAMP_W    = 48;
    localparam int EOUT_W     = 64;
    localparam int IV_W       = CUR_W + VOLT_W;
    localparam int DIGIT_W    = 24;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // Register reset values
    localparam logic [VOLT_W-1:0] SUPPLY_MV_RST  = VOLT_W'(3300);
    localparam logic [CUR_W-1:0]  TX_CUR_RST     = CUR_W'(435000);
    localparam logic [CUR_W-1:0]  RX_CUR_RST     = CUR_W'(112000);
    localparam logic [CUR_W-1:0]  STANDBY_CUR_RST = CUR_W'(14000);
    localparam logic [CUR_W-1:0]  SLEEP_CUR_RST  = CUR_W'(18);

    typedef enum logic [1:0] {
        CMD_CHANGE  = 2'd0,
        CMD_TX_LOAD = 2'd1,
        CMD_DEPLETE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        PS_SLEEP   = 2'd0,
        PS_STANDBY = 2'd1,
        PS_TX      = 2'd2,
        PS_RX      = 2'd3
    } pstate_t;

    typedef enum logic [2:0] {
        REG_SUPPLY_MV   = 3'd0,
        REG_TX_DEFAULT  = 3'd1,
        REG_RX_CUR      = 3'd2,
        REG_STANDBY_CUR = 3'd3,
        REG_SLEEP_CUR   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        cmd_t               cmd;
        pstate_t            new_state;
        logic [STAMP_W-1:0] now_time;
        logic [CUR_W-1:0]   tx_current_load;
    } req_t;

    typedef struct packed {
        pstate_t            current_state;
        logic               depleted;
        logic [CUR_W-1:0]   present_current;
        logic [EOUT_W-1:0]  total_energy;
        logic [EOUT_W-1:0]  tx_energy;
        logic [EOUT_W-1:0]  rx_energy;
        logic [EOUT_W-1:0]  standby_energy;
        logic [EOUT_W-1:0]  sleep_energy;
        logic [STAMP_W-1:0] tx_time;
        logic [STAMP_W-1:0] rx_time;
        logic [STAMP_W-1:0] standby_time;
        logic [STAMP_W-1:0] sleep_time;
    } res_t;

    // Register values as seen by the datapath
    typedef struct packed {
        logic [VOLT_W-1:0] supply_mv;
        logic [CUR_W-1:0]  rx_cur;
        logic [CUR_W-1:0]  standby_cur;
        logic [CUR_W-1:0]  sleep_cur;
        logic              tx_wr;
        logic [CUR_W-1:0]  tx_wdata;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic mul_step;
        logic accum;
        logic publish;
    } dp_ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic mul_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

### sv/rpsem_cfg.sv
// Configuration register file of the energy meter, APB-style write/read port.
// Depends on rpsem_pkg.
`default_nettype none

module rpsem_cfg
    import rpsem_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [VOLT_W-1:0] supply_mv_reg;
    logic [CUR_W-1:0]  tx_default_reg;
    logic [CUR_W-1:0]  rx_cur_reg;
    logic [CUR_W-1:0]  standby_cur_reg;
    logic [CUR_W-1:0]  sleep_cur_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_mv_reg   <= SUPPLY_MV_RST;
            tx_default_reg  <= TX_CUR_RST;
            rx_cur_reg      <= RX_CUR_RST;
            standby_cur_reg <= STANDBY_CUR_RST;
            sleep_cur_reg   <= SLEEP_CUR_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SUPPLY_MV:   supply_mv_reg   <= pwdata[VOLT_W-1:0];
                REG_TX_DEFAULT:  tx_default_reg  <= pwdata[CUR_W-1:0];
                REG_RX_CUR:      rx_cur_reg      <= pwdata[CUR_W-1:0];
                REG_STANDBY_CUR: standby_cur_reg <= pwdata[CUR_W-1:0];
                REG_SLEEP_CUR:   sleep_cur_reg   <= pwdata[CUR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SUPPLY_MV:   prdata = CFG_DATA_W'(supply_mv_reg);
            REG_TX_DEFAULT:  prdata = CFG_DATA_W'(tx_default_reg);
            REG_RX_CUR:      prdata = CFG_DATA_W'(rx_cur_reg);
            REG_STANDBY_CUR: prdata = CFG_DATA_W'(standby_cur_reg);
            REG_SLEEP_CUR:   prdata = CFG_DATA_W'(sleep_cur_reg);
            default:         prdata = '0;
        endcase
    end

    // A write of the tx default also reloads the active tx current
    assign cfg.supply_mv   = supply_mv_reg;
    assign cfg.rx_cur      = rx_cur_reg;
    assign cfg.standby_cur = standby_cur_reg;
    assign cfg.sleep_cur   = sleep_cur_reg;
    assign cfg.tx_wr       = wr_en && (idx == REG_TX_DEFAULT);
    assign cfg.tx_wdata    = pwdata[CUR_W-1:0];

endmodule

`default_nettype wire

### sv/rpsem_ctrl.sv
// Sequencing state machine of the energy meter: accept, multiply steps,
// accumulate, publish. Depends on rpsem_pkg.
`default_nettype none

module rpsem_ctrl
    import rpsem_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  cmd_t      in_cmd,
    output logic      in_stall,
    output dp_ctrl_t  ctrl,
    input  dp_stat_t  stat
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_PUB  = 4'b1000
    } fsm_t;

    fsm_t state_reg;
    fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                ctrl.accept = in_valid;
                if (in_valid)
                begin
                    state_next = (in_cmd == CMD_CHANGE) ? ST_MUL : ST_PUB;
                end
            end
            ST_MUL:
            begin
                ctrl.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                ctrl.accum = 1'b1;
                state_next = ST_PUB;
            end
            ST_PUB:
            begin
                // hold until the result register is free
                ctrl.publish = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/rpsem_dp.sv
// Datapath of the energy meter: state, duration, current-times-voltage
// product, digit-serial energy product, saturating accumulators and result
// register. Depends on rpsem_pkg.
`default_nettype none

module rpsem_dp
    import rpsem_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int ENERGY_BITS = ENERGY_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  dp_ctrl_t  ctrl,
    output dp_stat_t  stat,
    input  req_t      req,
    input  cfg_t      cfg,
    output res_t      res,
    output logic      res_valid,
    input  wire logic res_stall
);

    localparam int NDIG   = (TIME_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int DUR_W  = NDIG * DIGIT_W;
    localparam int PROD_W = DUR_W + IV_W;
    localparam int PP_W   = DIGIT_W + IV_W;
    localparam int DIG_W  = $clog2(NDIG);

    pstate_t                pstate_reg;
    logic                   depleted_reg;
    logic [TIME_BITS-1:0]   stamp_reg;
    logic [CUR_W-1:0]       tx_cur_reg;
    logic [ENERGY_BITS-1:0] energy_reg [4];
    logic [TIME_BITS-1:0]   time_reg [4];
    logic [ENERGY_BITS-1:0] total_reg;
    logic                   res_valid_reg;

    pstate_t                req_state_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [IV_W-1:0]        iv_reg;
    logic [DUR_W-1:0]       dur_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [DIG_W-1:0]       dig_reg;
    res_t                   res_reg;

    logic [TIME_BITS-1:0]   now_tb;
    logic [TIME_BITS:0]     diff;
    logic [TIME_BITS-1:0]   dur_new;
    logic [CUR_W-1:0]       cur_now;
    logic [IV_W-1:0]        iv_new;
    logic [DIGIT_W-1:0]     digit;
    logic [PP_W-1:0]        pp;
    logic [PROD_W-1:0]      prod_add;
    logic [ENERGY_BITS-1:0] e_sat;
    logic [ENERGY_BITS:0]   e_sum;
    logic [ENERGY_BITS:0]   tot_sum;
    logic [TIME_BITS:0]     t_sum;
    res_t                   res_next;

    assign now_tb  = TIME_BITS'(req.now_time);
    assign diff    = {1'b0, now_tb} - {1'b0, stamp_reg};
    // a timestamp behind the last one closes an empty interval
    assign dur_new = diff[TIME_BITS] ? '0 : diff[TIME_BITS-1:0];

    always_comb
    begin
        case (pstate_reg)
            PS_SLEEP:   cur_now = cfg.sleep_cur;
            PS_STANDBY: cur_now = cfg.standby_cur;
            PS_TX:      cur_now = tx_cur_reg;
            PS_RX:      cur_now = cfg.rx_cur;
            default:    cur_now = cfg.sleep_cur;
        endcase
    end

    assign iv_new   = IV_W'(cur_now) * IV_W'(cfg.supply_mv);
    assign digit    = dur_reg[dig_reg*DIGIT_W +: DIGIT_W];
    assign pp       = PP_W'(digit) * PP_W'(iv_reg);
    assign prod_add = prod_reg + (PROD_W'(pp) << (dig_reg * DIGIT_W));

    assign e_sat   = (|prod_reg[PROD_W-1:ENERGY_BITS]) ? '1 : prod_reg[ENERGY_BITS-1:0];
    assign e_sum   = {1'b0, energy_reg[pstate_reg]} + {1'b0, e_sat};
    assign tot_sum = {1'b0, total_reg} + {1'b0, e_sat};
    assign t_sum   = {1'b0, time_reg[pstate_reg]} + {1'b0, dur_reg[TIME_BITS-1:0]};

    assign stat.mul_last = (dig_reg == DIG_W'(NDIG - 1));
    assign stat.out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_next.current_state   = pstate_reg;
        res_next.depleted        = depleted_reg;
        res_next.present_current = cur_now;
        res_next.total_energy    = EOUT_W'(total_reg);
        res_next.tx_energy       = EOUT_W'(energy_reg[PS_TX]);
        res_next.rx_energy       = EOUT_W'(energy_reg[PS_RX]);
        res_next.standby_energy  = EOUT_W'(energy_reg[PS_STANDBY]);
        res_next.sleep_energy    = EOUT_W'(energy_reg[PS_SLEEP]);
        res_next.tx_time         = STAMP_W'(time_reg[PS_TX]);
        res_next.rx_time         = STAMP_W'(time_reg[PS_RX]);
        res_next.standby_time    = STAMP_W'(time_reg[PS_STANDBY]);
        res_next.sleep_time      = STAMP_W'(time_reg[PS_SLEEP]);
    end

    // Meter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pstate_reg    <= PS_SLEEP;
            depleted_reg  <= 1'b0;
            stamp_reg     <= '0;
            tx_cur_reg    <= TX_CUR_RST;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                energy_reg[i] <= '0;
                time_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cfg.tx_wr)
            begin
                tx_cur_reg <= cfg.tx_wdata;
            end
            if (ctrl.accept)
            begin
                case (req.cmd)
                    CMD_TX_LOAD: tx_cur_reg   <= req.tx_current_load;
                    CMD_DEPLETE: depleted_reg <= 1'b1;
                    default:     ;
                endcase
            end
            if (ctrl.accum)
            begin
                energy_reg[pstate_reg] <= e_sum[ENERGY_BITS] ? '1 : e_sum[ENERGY_BITS-1:0];
                total_reg <= tot_sum[ENERGY_BITS] ? '1 : tot_sum[ENERGY_BITS-1:0];
                time_reg[pstate_reg] <= t_sum[TIME_BITS] ? '1 : t_sum[TIME_BITS-1:0];
                stamp_reg <= now_reg;
                if (!depleted_reg)
                begin
                    pstate_reg <= req_state_reg;
                end
            end
            if (ctrl.publish)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            req_state_reg <= req.new_state;
            now_reg       <= now_tb;
            iv_reg        <= iv_new;
            dur_reg       <= DUR_W'(dur_new);
            prod_reg      <= '0;
            dig_reg       <= '0;
        end
        else if (ctrl.mul_step)
        begin
            prod_reg <= prod_add;
            dig_reg  <= DIG_W'(dig_reg + 1'b1);
        end
        if (ctrl.publish)
        begin
            res_reg <= res_next;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

### sv/radio_power_state_energy_meter.sv
// Radio power-state energy meter. One request at a time: a load-tx-current,
// depletion or unused command goes from acceptance straight to the publish state;
// a change-state request first passes through the digit-serial 24 x 33 bit
// multiplier that forms duration times current times voltage, one digit per cycle,
// then the accumulate state for saturating accumulation, then the publish state
// that loads the result register once it is no longer held downstream. The next
// request is taken once the result is loaded, while it still waits downstream.
// Energy is in 1e-16 J, time in us; all accumulators saturate.
`default_nettype none

module radio_power_state_energy_meter
    import rpsem_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int ENERGY_BITS = ENERGY_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  req_t                       in_req,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output res_t                       out_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t     cfg;
    dp_ctrl_t ctrl;
    dp_stat_t stat;

    rpsem_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpsem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_req.cmd),
        .in_stall (in_stall),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    rpsem_dp #(
        .TIME_BITS   (TIME_BITS),
        .ENERGY_BITS (ENERGY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .req       (in_req),
        .cfg       (cfg),
        .res       (out_res),
        .res_valid (out_valid),
        .res_stall (out_stall)
    );

endmodule

`default_nettype wire

### test/tb_radio_power_state_energy_meter.sv
`timescale 1ns / 100ps
// Self-checking testbench for the radio power-state energy meter: directed head table,
// random request phases under several register settings, then a directed tail table,
// checked against a local energy/time predictor. Depends on rpsem_pkg and the meter top level.

module tb_radio_power_state_energy_meter;

    import rpsem_pkg::*;

    localparam cmd_t            CMD_UNUSED = cmd_t'(2'd3);
    localparam logic [47:0]     STAMP_MAX  = '1;
    localparam int              HEAD_N     = 12;
    localparam int              TAIL_N     = 12;
    localparam int              PHASES     = 5;
    localparam int              PHASE_REQS = 190;
    localparam int              LONG_HOLD  = 300;

    typedef struct packed {
        req_t req;
        logic typed;
        res_t res;
    } step_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    req_t                  in_req    = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    res_t                  out_res;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state and register copies
    pstate_t      m_state;
    logic         m_depleted;
    logic [47:0]  m_stamp;
    logic [19:0]  m_tx_cur;
    logic [63:0]  m_energy [4];
    logic [47:0]  m_time [4];
    logic [63:0]  m_total;
    logic [12:0]  m_supply;
    logic [19:0]  m_rx_cur;
    logic [19:0]  m_sb_cur;
    logic [19:0]  m_sl_cur;

    res_t         pending_readings [$];
    int           mismatch_count = 0;
    int unsigned  tx_idle_pct = 0;
    int unsigned  rx_idle_pct = 0;
    int           hold_asks = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    radio_power_state_energy_meter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [19:0] draw_of(pstate_t s);
        case (s)
            PS_SLEEP:   return m_sl_cur;
            PS_STANDBY: return m_sb_cur;
            PS_TX:      return m_tx_cur;
            default:    return m_rx_cur;
        endcase
    endfunction

    function automatic res_t meter_step(req_t r);
        res_t        rd;
        int          s;
        logic [47:0] dur;
        logic [32:0] iv;
        logic [80:0] prod;
        logic [63:0] e;
        logic [64:0] esum;
        logic [48:0] tsum;
        case (r.cmd)
            CMD_CHANGE:
            begin
                s    = int'(m_state);
                // backward time counts as no time spent
                dur  = (r.now_time >= m_stamp) ? r.now_time - m_stamp : '0;
                iv   = 33'(draw_of(m_state)) * 33'(m_supply);
                prod = 81'(dur) * 81'(iv);
                e    = (prod[80:64] != '0) ? '1 : prod[63:0];
                esum = {1'b0, m_energy[s]} + {1'b0, e};
                m_energy[s] = esum[64] ? '1 : esum[63:0];
                esum = {1'b0, m_total} + {1'b0, e};
                m_total = esum[64] ? '1 : esum[63:0];
                tsum = {1'b0, m_time[s]} + {1'b0, dur};
                m_time[s] = tsum[48] ? '1 : tsum[47:0];
                m_stamp = r.now_time;
                if (!m_depleted)
                    m_state = r.new_state;
            end
            CMD_TX_LOAD: m_tx_cur = r.tx_current_load;
            CMD_DEPLETE: m_depleted = 1'b1;
            default: ;
        endcase
        rd.current_state   = m_state;
        rd.depleted        = m_depleted;
        rd.present_current = draw_of(m_state);
        rd.total_energy    = m_total;
        rd.tx_energy       = m_energy[int'(PS_TX)];
        rd.rx_energy       = m_energy[int'(PS_RX)];
        rd.standby_energy  = m_energy[int'(PS_STANDBY)];
        rd.sleep_energy    = m_energy[int'(PS_SLEEP)];
        rd.tx_time         = m_time[int'(PS_TX)];
        rd.rx_time         = m_time[int'(PS_RX)];
        rd.standby_time    = m_time[int'(PS_STANDBY)];
        rd.sleep_time      = m_time[int'(PS_SLEEP)];
        return rd;
    endfunction

    function automatic req_t mk_req(cmd_t c, pstate_t s, logic [47:0] t, logic [19:0] l);
        req_t r;
        r.cmd             = c;
        r.new_state       = s;
        r.now_time        = t;
        r.tx_current_load = l;
        return r;
    endfunction

    function automatic req_t random_req();
        req_t        r;
        int unsigned pick;
        logic [47:0] step;
        r.new_state       = pstate_t'(2'($urandom_range(0, 3)));
        r.tx_current_load = 20'($urandom);
        r.now_time        = {16'($urandom), $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            r.cmd = CMD_CHANGE;
            // move time in small steps, mostly forward, so the accumulators stay clear of saturation
            pick = $urandom_range(0, 99);
            if (pick < 70)
                step = 48'($urandom_range(0, 500));
            else if (pick < 85)
                step = 48'($urandom_range(0, 4096));
            else if (pick < 90)
                step = 48'($urandom_range(0, 65536));
            else
                step = '0;
            if (pick < 95)
                r.now_time = m_stamp + step;
            else
            begin
                step = 48'($urandom_range(1, 5000));
                r.now_time = (step > m_stamp) ? '0 : m_stamp - step;
            end
        end
        else if (pick < 92)
        begin
            r.cmd = CMD_TX_LOAD;
            if ($urandom_range(0, 1) == 0)
                r.tx_current_load = 20'($urandom_range(0, 1000000));
        end
        else
            r.cmd = CMD_UNUSED;
        return r;
    endfunction

    task automatic offer(req_t r, logic typed, res_t fixed);
        res_t pred;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = meter_step(r);
        pending_readings.push_back(typed ? fixed : pred);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t idx, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_SUPPLY_MV:   m_supply = data[12:0];
            REG_TX_DEFAULT:  m_tx_cur = data[19:0];
            REG_RX_CUR:      m_rx_cur = data[19:0];
            REG_STANDBY_CUR: m_sb_cur = data[19:0];
            default:         m_sl_cur = data[19:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, out_res);
                mismatch_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                cmp_field("current_state", 64'(want.current_state), 64'(out_res.current_state));
                cmp_field("depleted", 64'(want.depleted), 64'(out_res.depleted));
                cmp_field("present_current", 64'(want.present_current),
                          64'(out_res.present_current));
                cmp_field("total_energy", want.total_energy, out_res.total_energy);
                cmp_field("tx_energy", want.tx_energy, out_res.tx_energy);
                cmp_field("rx_energy", want.rx_energy, out_res.rx_energy);
                cmp_field("standby_energy", want.standby_energy, out_res.standby_energy);
                cmp_field("sleep_energy", want.sleep_energy, out_res.sleep_energy);
                cmp_field("tx_time", 64'(want.tx_time), 64'(out_res.tx_time));
                cmp_field("rx_time", 64'(want.rx_time), 64'(out_res.rx_time));
                cmp_field("standby_time", 64'(want.standby_time), 64'(out_res.standby_time));
                cmp_field("sleep_time", 64'(want.sleep_time), 64'(out_res.sleep_time));
            end
        end
    end

    initial
    begin
        step_row_t   head_tab [HEAD_N];
        step_row_t   tail_tab [TAIL_N];
        res_t        idle_res;
        res_t        tx_zero_res;
        res_t        tx_full_res;
        logic [12:0] ph_mv [PHASES];
        logic [19:0] ph_tx [PHASES];
        logic [19:0] ph_rx [PHASES];
        logic [19:0] ph_sb [PHASES];
        logic [19:0] ph_sl [PHASES];

        m_state    = PS_SLEEP;
        m_depleted = 1'b0;
        m_stamp    = '0;
        m_total    = '0;
        m_supply   = SUPPLY_MV_RST;
        m_tx_cur   = TX_CUR_RST;
        m_rx_cur   = RX_CUR_RST;
        m_sb_cur   = STANDBY_CUR_RST;
        m_sl_cur   = SLEEP_CUR_RST;
        for (int i = 0; i < 4; i++)
        begin
            m_energy[i] = '0;
            m_time[i]   = '0;
        end

        idle_res                     = '0;
        idle_res.current_state       = PS_SLEEP;
        idle_res.present_current     = SLEEP_CUR_RST;
        tx_zero_res                  = '0;
        tx_zero_res.current_state    = PS_TX;
        tx_full_res                  = tx_zero_res;
        tx_full_res.present_current  = 20'hFFFFF;

        // reset registers; unused fields carry junk throughout
        head_tab[0]  = '{mk_req(CMD_UNUSED, PS_RX, STAMP_MAX, 20'hFFFFF), 1'b1, idle_res};
        head_tab[1]  = '{mk_req(CMD_TX_LOAD, PS_RX, STAMP_MAX, 20'd0), 1'b1, idle_res};
        head_tab[2]  = '{mk_req(CMD_CHANGE, PS_TX, 48'd0, 20'hFFFFF), 1'b1, tx_zero_res};
        head_tab[3]  = '{mk_req(CMD_TX_LOAD, PS_SLEEP, 48'hA5A5_5A5A_F00F, 20'hFFFFF),
                         1'b1, tx_full_res};
        head_tab[4]  = '{mk_req(CMD_CHANGE, PS_RX, 48'd1000, 20'h5A5A5), 1'b0, '0};
        head_tab[5]  = '{mk_req(CMD_CHANGE, PS_STANDBY, 48'd400, 20'd0), 1'b0, '0};
        head_tab[6]  = '{mk_req(CMD_CHANGE, PS_SLEEP, 48'd5400, 20'd0), 1'b0, '0};
        head_tab[7]  = '{mk_req(CMD_CHANGE, PS_TX, 48'd9000, 20'd0), 1'b0, '0};
        head_tab[8]  = '{mk_req(CMD_TX_LOAD, PS_STANDBY, 48'd0, 20'd1000000), 1'b0, '0};
        head_tab[9]  = '{mk_req(CMD_CHANGE, PS_RX, 48'd9100, 20'd0), 1'b0, '0};
        head_tab[10] = '{mk_req(CMD_UNUSED, PS_RX, STAMP_MAX, 20'hFFFFF), 1'b0, '0};
        head_tab[11] = '{mk_req(CMD_CHANGE, PS_SLEEP, 48'd9100, 20'd0), 1'b0, '0};

        // saturation, then the sticky depleted flag
        tail_tab[0]  = '{mk_req(CMD_TX_LOAD, PS_RX, 48'd77, 20'hFFFFF), 1'b0, '0};
        tail_tab[1]  = '{mk_req(CMD_CHANGE, PS_TX, 48'd0, 20'd0), 1'b0, '0};
        tail_tab[2]  = '{mk_req(CMD_CHANGE, PS_TX, STAMP_MAX, 20'd0), 1'b0, '0};
        tail_tab[3]  = '{mk_req(CMD_CHANGE, PS_TX, 48'd0, 20'd0), 1'b0, '0};
        tail_tab[4]  = '{mk_req(CMD_CHANGE, PS_RX, STAMP_MAX, 20'd0), 1'b0, '0};
        tail_tab[5]  = '{mk_req(CMD_CHANGE, PS_RX, STAMP_MAX, 20'd0), 1'b0, '0};
        tail_tab[6]  = '{mk_req(CMD_DEPLETE, PS_TX, STAMP_MAX, 20'hFFFFF), 1'b0, '0};
        tail_tab[7]  = '{mk_req(CMD_CHANGE, PS_SLEEP, 48'd0, 20'd0), 1'b0, '0};
        tail_tab[8]  = '{mk_req(CMD_TX_LOAD, PS_SLEEP, 48'd0, 20'd5), 1'b0, '0};
        tail_tab[9]  = '{mk_req(CMD_UNUSED, PS_RX, STAMP_MAX, 20'hFFFFF), 1'b0, '0};
        tail_tab[10] = '{mk_req(CMD_CHANGE, PS_STANDBY, 48'd1234, 20'd0), 1'b0, '0};
        tail_tab[11] = '{mk_req(CMD_DEPLETE, PS_SLEEP, 48'd0, 20'd0), 1'b0, '0};

        ph_mv[0] = 13'd5000;  ph_tx[0] = 20'd1000000; ph_rx[0] = 20'd1000000;
        ph_sb[0] = 20'd1000000; ph_sl[0] = 20'd1000000;
        ph_mv[1] = 13'd0;     ph_tx[1] = 20'd0;       ph_rx[1] = 20'd0;
        ph_sb[1] = 20'd0;     ph_sl[1] = 20'd0;
        ph_mv[2] = 13'($urandom_range(0, 5000));
        ph_tx[2] = 20'($urandom_range(0, 1000000));
        ph_rx[2] = 20'($urandom_range(0, 1000000));
        ph_sb[2] = 20'($urandom_range(0, 1000000));
        ph_sl[2] = 20'($urandom_range(0, 1000000));
        ph_mv[3] = SUPPLY_MV_RST; ph_tx[3] = TX_CUR_RST; ph_rx[3] = RX_CUR_RST;
        ph_sb[3] = STANDBY_CUR_RST; ph_sl[3] = SLEEP_CUR_RST;
        ph_mv[4] = 13'h1FFF;  ph_tx[4] = 20'hFFFFF;   ph_rx[4] = 20'hFFFFF;
        ph_sb[4] = 20'hFFFFF; ph_sl[4] = 20'hFFFFF;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < HEAD_N; i++)
            offer(head_tab[i].req, head_tab[i].typed, head_tab[i].res);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            tx_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 73 : 0;
            rx_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 35 : 0;
            // junk above each register's width must be dropped
            apb_write(REG_SUPPLY_MV,   {19'($urandom), ph_mv[ph]});
            apb_write(REG_TX_DEFAULT,  {12'($urandom), ph_tx[ph]});
            apb_write(REG_RX_CUR,      {12'($urandom), ph_rx[ph]});
            apb_write(REG_STANDBY_CUR, {12'($urandom), ph_sb[ph]});
            apb_write(REG_SLEEP_CUR,   {12'($urandom), ph_sl[ph]});
            // hold the result side off while requests keep coming
            if (ph == 2)
                hold_asks++;
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                if (ph == 1 && n == PHASE_REQS / 2)
                    drain_results();
                offer(random_req(), 1'b0, '0);
            end
            drain_results();
        end

        for (int i = 0; i < TAIL_N; i++)
            offer(tail_tab[i].req, tail_tab[i].typed, tail_tab[i].res);
        drain_results();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
sv/rpsem_pkg.sv
sv/rpsem_cfg.sv
sv/rpsem_ctrl.sv
sv/rpsem_dp.sv
sv/radio_power_state_energy_meter.sv
test/tb_radio_power_state_energy_meter.sv
